// File: design/avc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_pkg
// Shared codes and sequencer states of the address verdict cache.
// ----------------------------------------------------------------------------
package avc_pkg;

	localparam logic [1:0] OP_CHECK  = 2'd0;
	localparam logic [1:0] OP_REPLY  = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_IGNORE = 2'd3;

	localparam logic [1:0] KIND_CACHED  = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_ANSWER  = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [15:0] TTL_RESET = 16'd60;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CSCAN,
		ST_PSCAN,
		ST_PINS,
		ST_RSCAN,
		ST_RDEL,
		ST_CSTO,
		ST_DONE
	} state_t;

endpackage

// File: design/avc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module avc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/address_verdict_cache_with_expiry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_verdict_cache_with_expiry_unit
// Verdict cache with expiry plus a table of outstanding queries.
// ----------------------------------------------------------------------------
// Input requests (op, ip, request_id, deny) enter on item_valid/item_stall;
// results (kind, deny_res, request_id_res, ip_res) leave on
// result_valid/result_stall through an output register, so a new request is
// taken while the last result still waits. A tick advances the clock and
// gives no result. Cache and pending table sit in RAMs with registered reads
// and are walked one entry per cycle by a sequencer, in these passes:
//   check:  a cache scan, which ends on a live hit; else a pending scan,
//           which ends on a full table; else an insert pass
//   reply:  a pending scan, which ends on an unknown id; else a delete
//           pass, then a cache store scan
// (C = CACHE_ENTRIES, P = PENDING_ENTRIES). The next request is taken once
// the sequencer is idle again. One request is in work at a time. After reset
// a clearing pass over max(C, P) entries zeroes both RAMs; item_stall is high
// meanwhile, ttl writes are taken at any time. A stalled result holds in the
// output register and a finished request waits until that register frees.
// ----------------------------------------------------------------------------
module address_verdict_cache_with_expiry_unit #(
	parameter int CACHE_ENTRIES   = 64,
	parameter int PENDING_ENTRIES = 16,
	parameter int ID_BITS         = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic [31:0] ip,
	input  logic [15:0] request_id,
	input  logic        deny,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic        deny_res,
	output logic [15:0] request_id_res,
	output logic [31:0] ip_res
);

	localparam int CIW   = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PIW   = PENDING_ENTRIES > 1 ? $clog2(PENDING_ENTRIES) : 1;
	localparam int IW    = CIW > PIW ? CIW : PIW;
	localparam int CLR_N = CACHE_ENTRIES > PENDING_ENTRIES ? CACHE_ENTRIES : PENDING_ENTRIES;
	localparam int AW    = PIW;
	localparam int CW    = 66;
	localparam int PW    = 1 + 32 + ID_BITS + AW;
	localparam logic [IW-1:0] C_LAST   = IW'(CACHE_ENTRIES - 1);
	localparam logic [IW-1:0] P_LAST   = IW'(PENDING_ENTRIES - 1);
	localparam logic [IW-1:0] CLR_LAST = IW'(CLR_N - 1);

	avc_pkg::state_t state_q, state_d;

	logic [15:0]        ttl_q;
	logic [31:0]        clock_q;
	logic [IW-1:0]      idx_q, idx_s1, last_idx;
	logic               go_q, v_s1, end_s2;
	logic [31:0]        key_q;
	logic [15:0]        id_q;
	logic               deny_q;
	logic               hit_q, live_q, verdict_q;
	logic               free_q, found_q;
	logic [PIW-1:0]     slot_q;
	logic [ID_BITS-1:0] nid_q, nid_next;
	logic [31:0]        paddr_q;
	logic [AW-1:0]      age_q;
	logic               same_q, inv_q;
	logic [CIW-1:0]     same_idx_q, inv_idx_q, min_idx_q, cslot;
	logic [31:0]        min_exp_q;
	logic               res_valid_q;
	logic [1:0]         kind_q, r_kind;
	logic               deny_res_q, r_deny;
	logic [15:0]        rid_q, r_id;
	logic [31:0]        rip_q, r_ip;
	logic [1:0]         pk_q;
	logic               pd_q;
	logic [15:0]        pid_q;
	logic [31:0]        pip_q;
	logic               r_load, accept, is_scan_d;

	logic               cwe, pwe;
	logic [CIW-1:0]     cwa;
	logic [PIW-1:0]     pwa;
	logic [CW-1:0]      cwd, c_rd;
	logic [PW-1:0]      pwd, p_rd;

	logic               c_valid, c_verdict, c_match, c_expired;
	logic [31:0]        c_addr, c_exp;
	logic               p_valid;
	logic [31:0]        p_addr;
	logic [ID_BITS-1:0] p_tag, rid_key;
	logic [AW-1:0]      p_age;
	logic [ID_BITS+15:0] rid_ext, nid_ext;

	avc_ram #(.WIDTH(CW), .DEPTH(CACHE_ENTRIES)) u_cache (
		.clk   (clk),
		.we    (cwe),
		.waddr (cwa),
		.wdata (cwd),
		.raddr (idx_q[CIW-1:0]),
		.rdata (c_rd)
	);

	avc_ram #(.WIDTH(PW), .DEPTH(PENDING_ENTRIES)) u_pend (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwa),
		.wdata (pwd),
		.raddr (idx_q[PIW-1:0]),
		.rdata (p_rd)
	);

	assign c_valid   = c_rd[CW-1];
	assign c_verdict = c_rd[CW-2];
	assign c_exp     = c_rd[63:32];
	assign c_addr    = c_rd[31:0];
	assign p_valid   = p_rd[PW-1];
	assign p_addr    = p_rd[PW-2 -: 32];
	assign p_tag     = p_rd[AW+ID_BITS-1:AW];
	assign p_age     = p_rd[AW-1:0];

	assign rid_ext   = {{ID_BITS{1'b0}}, id_q};
	assign rid_key   = rid_ext[ID_BITS-1:0];
	assign nid_ext   = {16'b0, nid_q};

	assign c_match   = c_valid && (c_addr == key_q);
	assign c_expired = c_exp <= clock_q;

	always_comb begin
		nid_next = ID_BITS'(p_tag + 1'b1);
		if (nid_next == '0) begin
			nid_next = ID_BITS'(1);
		end
	end

	assign cslot = same_q ? same_idx_q : (inv_q ? inv_idx_q : min_idx_q);

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != avc_pkg::ST_IDLE);

	always_comb begin
		unique case (state_q)
			avc_pkg::ST_CSCAN, avc_pkg::ST_CSTO: last_idx = C_LAST;
			default:                              last_idx = P_LAST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= avc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cwe     = 1'b0;
		cwa     = idx_s1[CIW-1:0];
		cwd     = '0;
		pwe     = 1'b0;
		pwa     = idx_s1[PIW-1:0];
		pwd     = '0;
		r_load  = 1'b0;
		r_kind  = avc_pkg::KIND_ERROR;
		r_deny  = 1'b0;
		r_id    = '0;
		r_ip    = key_q;
		unique case (state_q)
			avc_pkg::ST_CLEAR: begin
				cwa = idx_q[CIW-1:0];
				pwa = idx_q[PIW-1:0];
				cwe = (idx_q <= C_LAST);
				pwe = (idx_q <= P_LAST);
				if (idx_q == CLR_LAST) begin
					state_d = avc_pkg::ST_IDLE;
				end
			end
			avc_pkg::ST_IDLE: begin
				if (accept && op == avc_pkg::OP_CHECK) begin
					state_d = avc_pkg::ST_CSCAN;
				end else if (accept && op == avc_pkg::OP_REPLY) begin
					state_d = avc_pkg::ST_RSCAN;
				end
			end
			avc_pkg::ST_CSCAN: begin
				// drop an expired entry and fall through to a miss
				if (v_s1 && c_match && !hit_q && c_expired) begin
					cwe = 1'b1;
					cwd = {1'b0, c_rd[CW-2:0]};
				end
				if (end_s2) begin
					if (live_q) begin
						state_d = avc_pkg::ST_DONE;
						r_load  = 1'b1;
						r_kind  = avc_pkg::KIND_CACHED;
						r_deny  = verdict_q;
					end else begin
						state_d = avc_pkg::ST_PSCAN;
					end
				end
			end
			avc_pkg::ST_PSCAN: begin
				if (end_s2) begin
					if (!free_q) begin
						state_d = avc_pkg::ST_DONE;
						r_load  = 1'b1;
					end else begin
						state_d = avc_pkg::ST_PINS;
					end
				end
			end
			avc_pkg::ST_PINS: begin
				// age every live entry and place the new one
				if (v_s1 && idx_s1[PIW-1:0] == slot_q) begin
					pwe = 1'b1;
					pwd = {1'b1, key_q, nid_q, {AW{1'b0}}};
				end else if (v_s1 && p_valid) begin
					pwe = 1'b1;
					pwd = {p_rd[PW-1:AW], AW'(p_age + 1'b1)};
				end
				if (end_s2) begin
					state_d = avc_pkg::ST_DONE;
					r_load  = 1'b1;
					r_kind  = avc_pkg::KIND_REQUEST;
					r_id    = nid_ext[15:0];
				end
			end
			avc_pkg::ST_RSCAN: begin
				if (end_s2) begin
					if (!found_q) begin
						state_d = avc_pkg::ST_DONE;
						r_load  = 1'b1;
						r_id    = id_q;
						r_ip    = '0;
					end else begin
						state_d = avc_pkg::ST_RDEL;
					end
				end
			end
			avc_pkg::ST_RDEL: begin
				if (v_s1 && idx_s1[PIW-1:0] == slot_q) begin
					pwe = 1'b1;
					pwd = {1'b0, p_rd[PW-2:0]};
				end else if (v_s1 && p_valid && p_age > age_q) begin
					pwe = 1'b1;
					pwd = {p_rd[PW-1:AW], AW'(p_age - 1'b1)};
				end
				if (end_s2) begin
					state_d = avc_pkg::ST_CSTO;
				end
			end
			avc_pkg::ST_CSTO: begin
				if (end_s2) begin
					cwe     = 1'b1;
					cwa     = cslot;
					cwd     = {1'b1, deny_q, clock_q + {16'b0, ttl_q}, paddr_q};
					state_d = avc_pkg::ST_DONE;
					r_load  = 1'b1;
					r_kind  = avc_pkg::KIND_ANSWER;
					r_deny  = deny_q;
					r_id    = id_q;
					r_ip    = paddr_q;
				end
			end
			avc_pkg::ST_DONE: begin
				if (!res_valid_q || !result_stall) begin
					state_d = avc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = avc_pkg::ST_IDLE;
			end
		endcase
	end

	assign is_scan_d = (state_d == avc_pkg::ST_CSCAN) || (state_d == avc_pkg::ST_PSCAN) ||
		(state_d == avc_pkg::ST_PINS) || (state_d == avc_pkg::ST_RSCAN) ||
		(state_d == avc_pkg::ST_RDEL) || (state_d == avc_pkg::ST_CSTO);

	// scan address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			go_q   <= 1'b0;
			v_s1   <= 1'b0;
			end_s2 <= 1'b0;
		end else begin
			v_s1   <= go_q;
			end_s2 <= v_s1 && (idx_s1 == last_idx);
			if (state_d != state_q) begin
				idx_q  <= '0;
				go_q   <= is_scan_d;
				v_s1   <= 1'b0;
				end_s2 <= 1'b0;
			end else if (state_q == avc_pkg::ST_CLEAR) begin
				idx_q <= IW'(idx_q + 1'b1);
			end else if (go_q) begin
				if (idx_q == last_idx) begin
					go_q <= 1'b0;
				end else begin
					idx_q <= IW'(idx_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q   <= avc_pkg::TTL_RESET;
			clock_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				ttl_q <= cfg_wr_data;
			end
			if (accept && op == avc_pkg::OP_TICK) begin
				clock_q <= clock_q + 32'd1;
			end
		end
	end

	// per-request search state
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= ip;
			id_q    <= request_id;
			deny_q  <= deny;
			hit_q   <= 1'b0;
			live_q  <= 1'b0;
			free_q  <= 1'b0;
			found_q <= 1'b0;
			same_q  <= 1'b0;
			inv_q   <= 1'b0;
			nid_q   <= ID_BITS'(1);
		end else if (state_q == avc_pkg::ST_RDEL && end_s2) begin
			// placement compares against the replied address
			key_q <= paddr_q;
		end else if (v_s1) begin
			unique case (state_q)
				avc_pkg::ST_CSCAN: begin
					if (c_match && !hit_q) begin
						hit_q     <= 1'b1;
						live_q    <= !c_expired;
						verdict_q <= c_verdict;
					end
				end
				avc_pkg::ST_PSCAN: begin
					if (!p_valid && !free_q) begin
						free_q <= 1'b1;
						slot_q <= idx_s1[PIW-1:0];
					end
					if (p_valid && p_age == '0) begin
						nid_q <= nid_next;
					end
				end
				avc_pkg::ST_RSCAN: begin
					if (p_valid && p_tag == rid_key && !found_q) begin
						found_q <= 1'b1;
						slot_q  <= idx_s1[PIW-1:0];
						paddr_q <= p_addr;
						age_q   <= p_age;
					end
				end
				avc_pkg::ST_CSTO: begin
					if (c_match && !same_q) begin
						same_q     <= 1'b1;
						same_idx_q <= idx_s1[CIW-1:0];
					end
					if (!c_valid && !inv_q) begin
						inv_q     <= 1'b1;
						inv_idx_q <= idx_s1[CIW-1:0];
					end
					if (idx_s1 == '0 || c_exp < min_exp_q) begin
						min_exp_q <= c_exp;
						min_idx_q <= idx_s1[CIW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (r_load) begin
			pk_q  <= r_kind;
			pd_q  <= r_deny;
			pid_q <= r_id;
			pip_q <= r_ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == avc_pkg::ST_DONE && (!res_valid_q || !result_stall)) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == avc_pkg::ST_DONE && (!res_valid_q || !result_stall)) begin
			kind_q     <= pk_q;
			deny_res_q <= pd_q;
			rid_q      <= pid_q;
			rip_q      <= pip_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign kind           = kind_q;
	assign deny_res       = deny_res_q;
	assign request_id_res = rid_q;
	assign ip_res         = rip_q;

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == avc_pkg::ST_DONE && (!res_valid_q || !result_stall)) |=> res_valid_q)
		else $error("finished request did not reach the output register");

	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q != avc_pkg::ST_IDLE && state_q != avc_pkg::ST_DONE &&
			state_q != avc_pkg::ST_CLEAR))
		else $error("read data flagged outside a scan");

	a_no_rmw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(pwe && go_q && state_q != avc_pkg::ST_CLEAR) |-> (pwa != idx_q[PIW-1:0]))
		else $error("pending write overlaps the entry being read");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		r_load |=> state_q == avc_pkg::ST_DONE)
		else $error("result staged without entering done");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the address verdict cache with expiry.
// ----------------------------------------------------------------------------
// Check, reply, tick and ignored requests are sent through the handshake.
// A predictor in the bench keeps its own cache and pending table and works
// out each verdict. Each result the block returns is compared field by field
// with the oldest waiting prediction. Both sides idle at random, and the
// receiver holds off long enough that the block stalls its input.
// ----------------------------------------------------------------------------
module tb;

	localparam int CACHE_SLOTS   = 64;
	localparam int PENDING_SLOTS = 16;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [1:0]  kind;
		logic        deny;
		logic [15:0] id;
		logic [31:0] ip;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  op = avc_pkg::OP_TICK;
	logic [31:0] ip = '0;
	logic [15:0] request_id = '0;
	logic        deny = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic        deny_res;
	logic [15:0] request_id_res;
	logic [31:0] ip_res;

	// predictor state
	logic [15:0] ttl_now;
	logic [31:0] seconds_now;
	logic        cache_used [CACHE_SLOTS];
	logic [31:0] cache_ip [CACHE_SLOTS];
	logic        cache_deny [CACHE_SLOTS];
	logic [31:0] cache_until [CACHE_SLOTS];
	logic        query_used [PENDING_SLOTS];
	logic [31:0] query_ip [PENDING_SLOTS];
	logic [15:0] query_id [PENDING_SLOTS];
	int unsigned query_rank [PENDING_SLOTS];

	verdict_t    verdict_q[$];
	int          failures = 0;
	bit          no_idle = 1'b0;
	bit          long_hold = 1'b0;
	logic [31:0] addr_pool [96];

	address_verdict_cache_with_expiry_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.op(op), .ip(ip), .request_id(request_id), .deny(deny),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .deny_res(deny_res),
		.request_id_res(request_id_res), .ip_res(ip_res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	function automatic void store_verdict(input logic [31:0] a, input logic dn,
			input logic [31:0] expires_at);
		int slot;
		slot = -1;
		for (int i = 0; i < CACHE_SLOTS && slot < 0; i++)
			if (cache_used[i] && cache_ip[i] == a) slot = i;
		for (int i = 0; i < CACHE_SLOTS && slot < 0; i++)
			if (!cache_used[i]) slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < CACHE_SLOTS; i++)
				if (cache_until[i] < cache_until[slot]) slot = i;
		end
		cache_used[slot] = 1'b1;
		cache_ip[slot] = a;
		cache_deny[slot] = dn;
		cache_until[slot] = expires_at;
	endfunction

	function automatic bit predict_verdict(input logic [1:0] o, input logic [31:0] a,
			input logic [15:0] rid, input logic dn, output verdict_t v);
		int slot;
		logic [15:0] nid;
		slot = -1;
		nid = 16'd1;
		v = '0;
		if (o == avc_pkg::OP_TICK) begin
			seconds_now = seconds_now + 32'd1;
			return 1'b0;
		end
		if (o == avc_pkg::OP_CHECK) begin
			for (int i = 0; i < CACHE_SLOTS; i++) begin
				if (cache_used[i] && cache_ip[i] == a) begin
					if (cache_until[i] <= seconds_now) begin
						cache_used[i] = 1'b0;
						break;
					end
					v = '{avc_pkg::KIND_CACHED, cache_deny[i], 16'd0, a};
					return 1'b1;
				end
			end
			for (int i = 0; i < PENDING_SLOTS; i++) begin
				if (!query_used[i] && slot < 0) slot = i;
				if (query_used[i] && query_rank[i] == 0) begin
					nid = query_id[i] + 16'd1;
					if (nid == 16'd0) nid = 16'd1;
				end
			end
			if (slot < 0) begin
				v = '{avc_pkg::KIND_ERROR, 1'b0, 16'd0, a};
				return 1'b1;
			end
			for (int i = 0; i < PENDING_SLOTS; i++)
				if (query_used[i]) query_rank[i]++;
			query_used[slot] = 1'b1;
			query_ip[slot] = a;
			query_id[slot] = nid;
			query_rank[slot] = 0;
			v = '{avc_pkg::KIND_REQUEST, 1'b0, nid, a};
			return 1'b1;
		end
		if (o == avc_pkg::OP_REPLY) begin
			for (int i = 0; i < PENDING_SLOTS && slot < 0; i++)
				if (query_used[i] && query_id[i] == rid) slot = i;
			if (slot < 0) begin
				v = '{avc_pkg::KIND_ERROR, 1'b0, rid, 32'd0};
				return 1'b1;
			end
			query_used[slot] = 1'b0;
			for (int i = 0; i < PENDING_SLOTS; i++)
				if (query_used[i] && query_rank[i] > query_rank[slot]) query_rank[i]--;
			store_verdict(query_ip[slot], dn, seconds_now + 32'(ttl_now));
			v = '{avc_pkg::KIND_ANSWER, dn, rid, query_ip[slot]};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input logic [1:0] o, input logic [31:0] a,
			input logic [15:0] rid, input logic dn);
		verdict_t v;
		int gap;
		item_valid <= 1'b1;
		op <= o;
		ip <= a;
		request_id <= rid;
		deny <= dn;
		do @(posedge clk); while (item_stall !== 1'b0);
		if (predict_verdict(o, a, rid, dn, v)) verdict_q.push_back(v);
		gap = (!no_idle && $urandom_range(99) < 23) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, wait for every result, then let the block go idle
	task automatic drain;
		item_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ttl(input logic [15:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		ttl_now = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int pick_pending();
		int live [$];
		for (int i = 0; i < PENDING_SLOTS; i++)
			if (query_used[i]) live.push_back(i);
		if (live.size() == 0) return -1;
		return live[$urandom_range(live.size() - 1)];
	endfunction

	task automatic answer_all;
		int s;
		s = pick_pending();
		while (s >= 0) begin
			send_item(avc_pkg::OP_REPLY, $urandom, query_id[s], 1'($urandom_range(1)));
			s = pick_pending();
		end
	endtask

	task automatic test_basic_ops;
		send_item(avc_pkg::OP_CHECK, 32'h0000_0000, 16'h0000, 1'b0);
		send_item(avc_pkg::OP_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_item(avc_pkg::OP_CHECK, 32'h0000_0000, 16'h0000, 1'b0);
		send_item(avc_pkg::OP_REPLY, 32'hFFFF_FFFF, 16'd1, 1'b0);
		send_item(avc_pkg::OP_REPLY, 32'h0000_0000, 16'd2, 1'b1);
		send_item(avc_pkg::OP_CHECK, 32'h0000_0000, 16'h0000, 1'b0);
		send_item(avc_pkg::OP_CHECK, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send_item(avc_pkg::OP_REPLY, 32'h0, 16'hFFFF, 1'b1);
		send_item(avc_pkg::OP_REPLY, 32'h0, 16'h0000, 1'b0);
		send_item(avc_pkg::OP_IGNORE, 32'hA5A5_5A5A, 16'h1234, 1'b1);
		send_item(avc_pkg::OP_TICK, 32'h0, 16'h0, 1'b0);
		send_item(avc_pkg::OP_REPLY, 32'h0, 16'd3, 1'b1);
	endtask

	task automatic test_expiry;
		write_ttl(16'd1);
		send_item(avc_pkg::OP_CHECK, 32'h0A00_0001, 16'h0, 1'b0);
		send_item(avc_pkg::OP_REPLY, 32'h0, query_id[pick_pending()], 1'b1);
		send_item(avc_pkg::OP_CHECK, 32'h0A00_0001, 16'h0, 1'b0);
		send_item(avc_pkg::OP_TICK, 32'h0, 16'h0, 1'b0);
		send_item(avc_pkg::OP_CHECK, 32'h0A00_0001, 16'h0, 1'b0);
		answer_all();
	endtask

	task automatic test_pending_full;
		write_ttl(16'hFFFF);
		for (int i = 0; i < PENDING_SLOTS + 2; i++)
			send_item(avc_pkg::OP_CHECK, 32'hC0A8_0000 + 32'(i), 16'h0, 1'b0);
		// free an older entry so the next id comes from the newest one
		send_item(avc_pkg::OP_REPLY, 32'h0, query_id[3], 1'b0);
		send_item(avc_pkg::OP_CHECK, 32'hC0A8_00FF, 16'h0, 1'b0);
		answer_all();
	endtask

	task automatic test_backpressure;
		long_hold = 1'b1;
		for (int i = 0; i < 10; i++)
			send_item(avc_pkg::OP_CHECK, addr_pool[$urandom_range(95)], 16'h0, 1'b0);
		answer_all();
		drain();
	endtask

	task automatic test_random_traffic(input int count);
		int r, s;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 42)
				send_item(avc_pkg::OP_CHECK,
					(r < 38) ? addr_pool[$urandom_range(95)] : $urandom,
					16'($urandom), 1'($urandom_range(1)));
			else if (r < 78) begin
				s = pick_pending();
				send_item(avc_pkg::OP_REPLY, $urandom,
					(s >= 0) ? query_id[s] : 16'($urandom), 1'($urandom_range(1)));
			end else if (r < 92)
				send_item(avc_pkg::OP_TICK, $urandom, 16'($urandom),
					1'($urandom_range(1)));
			else if (r < 97)
				send_item(avc_pkg::OP_REPLY, $urandom, 16'($urandom),
					1'($urandom_range(1)));
			else
				send_item(avc_pkg::OP_IGNORE, $urandom, 16'($urandom),
					1'($urandom_range(1)));
		end
	endtask

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
				result_stall <= 1'b0;
				long_hold = 1'b0;
			end else begin
				result_stall <= (!no_idle && $urandom_range(99) < 23);
			end
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				$error("result with nothing expected: kind %0d ip %h", kind, ip_res);
				failures++;
			end else begin
				e = verdict_q.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind);
					failures++;
				end
				if (deny_res !== e.deny) begin
					$error("deny_res: expected %0d, got %0d", e.deny, deny_res);
					failures++;
				end
				if (request_id_res !== e.id) begin
					$error("request_id_res: expected %0d, got %0d", e.id, request_id_res);
					failures++;
				end
				if (ip_res !== e.ip) begin
					$error("ip_res: expected %h, got %h", e.ip, ip_res);
					failures++;
				end
			end
		end
	end

	initial begin
		ttl_now = avc_pkg::TTL_RESET;
		seconds_now = '0;
		for (int i = 0; i < CACHE_SLOTS; i++) cache_used[i] = 1'b0;
		for (int i = 0; i < PENDING_SLOTS; i++) query_used[i] = 1'b0;
		for (int i = 0; i < 96; i++) addr_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_expiry();
		test_pending_full();
		test_backpressure();
		write_ttl(16'd3);
		test_random_traffic(350);
		write_ttl(16'($urandom_range(1, 8)));
		no_idle = 1'b1;
		test_random_traffic(300);
		no_idle = 1'b0;
		write_ttl(16'd60);
		test_random_traffic(350);
		write_ttl(16'($urandom_range(2, 20)));
		test_random_traffic(350);
		drain();

		if (failures == 0 && verdict_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (verdict_q.size() != 0)
				$error("%0d expected results never arrived", verdict_q.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
